// File: rtl/rfc3339_timestamp_checker_core_assert.svh
// assertion macros shared by the timestamp checker
`ifndef RFC3339_TIMESTAMP_CHECKER_CORE_ASSERT_SVH
`define RFC3339_TIMESTAMP_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, held off while reset is high
`define RFCTS_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfcts: same-cycle check failed");

// next-cycle implication, held off while reset is high
`define RFCTS_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfcts: next-cycle check failed");

`endif

// File: rtl/rfcts_pkg.sv
package rfcts_pkg;

   // one character of the string with its end marker
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } item_type;

   // parse phase, one-hot
   typedef enum logic [5:0] {
      PH_FIXED     = 6'b000001,
      PH_AFTER_SEC = 6'b000010,
      PH_FRAC_NEED = 6'b000100,
      PH_FRAC      = 6'b001000,
      PH_ZONE      = 6'b010000,
      PH_DONE      = 6'b100000
   } phase_type;

   // character codes
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_T_UP  = 8'h54;
   localparam logic [7:0] CH_T_LO  = 8'h74;
   localparam logic [7:0] CH_Z_UP  = 8'h5A;
   localparam logic [7:0] CH_Z_LO  = 8'h7A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // places in the fixed part YYYY-MM-DDThh:mm:ss
   localparam logic [4:0] POS_YEAR_LO  = 5'd2;
   localparam logic [4:0] POS_DASH_1   = 5'd4;
   localparam logic [4:0] POS_DASH_2   = 5'd7;
   localparam logic [4:0] POS_T        = 5'd10;
   localparam logic [4:0] POS_COLON_1  = 5'd13;
   localparam logic [4:0] POS_COLON_2  = 5'd16;
   localparam logic [4:0] POS_LAST_FIX = 5'd18;

   // places after the zone sign hh:mm
   localparam logic [4:0] ZPOS_COLON = 5'd2;
   localparam logic [4:0] ZPOS_LAST  = 5'd4;

   // field limits
   localparam logic [6:0] MAX_HOUR   = 7'd23;
   localparam logic [6:0] MAX_MINUTE = 7'd59;
   localparam logic [6:0] MAX_SECOND = 7'd60;

   // append one decimal digit to a two-digit field
   function automatic logic [6:0] push_digit(input logic [6:0] acc, input logic [3:0] dig);
      push_digit = 7'(acc * 7'd10 + {3'b000, dig});
   endfunction

   // days in a month, zero for a month that does not exist
   function automatic logic [4:0] month_length(input logic [6:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                   len = 5'd30;
         7'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      month_length = len;
   endfunction

endpackage

// File: rtl/rfc3339_timestamp_checker_core.sv
// RFC 3339 timestamp checker.
// Request channel: one character per request on req_char_code, with
// req_last_char high on the final character of a string. A request is taken
// at a rising edge with req_valid high and req_stall low.
// Response channel: one response per string, rsp_is_valid high when the whole
// string is a well-formed date-time with a zone. Taken when rsp_valid is high
// and rsp_stall low.
// A request lands in the input register at the edge that takes it; the
// response register is loaded when a final character leaves the input
// register, which a stalled response can hold back.
// Throughput: one character per cycle while req_stall is low, set by the
// single pass of parse logic between the input and response registers.
// Stalls: characters that are not final keep flowing while a response waits.
// A final character stays in the input register while the previous response
// is still stalled, and req_stall is raised until the response slot frees.
// Reset: synchronous; clears the parse state, empties both registers and
// starts a new string.
module rfc3339_timestamp_checker_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_valid
);
   import rfcts_pkg::*;

   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_is_valid_ff;
   logic     out_free;
   logic     go;
   logic     take;
   logic     verdict;

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && (!in_item_ff.last_char || out_free);
   assign req_stall = in_valid_ff && !go;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !go);
   assign rsp_valid_in = (go && in_item_ff.last_char) || (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.char_code <= req_char_code;
         in_item_ff.last_char <= req_last_char;
      end
   end

   // character parser and field checks
   rfcts_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .item    (in_item_ff),
      .verdict (verdict)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && in_item_ff.last_char) begin
         rsp_is_valid_ff <= verdict;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;

   // checks
`include "rfc3339_timestamp_checker_core_assert.svh"

   // a character that ends no string never holds up the request side
   `RFCTS_IMPLIES(a_mid_char_flows, clock, reset, in_valid_ff && !in_item_ff.last_char, !req_stall)
   // a final character that leaves the input register yields a response
   `RFCTS_NEXT(a_final_gives_rsp, clock, reset, go && in_item_ff.last_char, rsp_valid)
   // a waiting final character is held back while the response is stalled
   `RFCTS_IMPLIES(a_final_waits, clock, reset, in_valid_ff && in_item_ff.last_char && rsp_valid && rsp_stall, req_stall)

endmodule

// File: rtl/rfcts_parser.sv
module rfcts_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  rfcts_pkg::item_type item,
   output logic               verdict
);
   import rfcts_pkg::*;

   // parse state
   phase_type  phase_ff, phase_in;
   logic [4:0] pos_ff, pos_in;
   logic       fail_ff, fail_in;
   // year kept as two pairs of digits, so leap tests need no division
   logic [6:0] year_hi_ff, year_hi_in;
   logic [6:0] year_lo_ff, year_lo_in;
   logic [6:0] month_ff, month_in;
   logic [6:0] day_ff, day_in;
   logic [6:0] hour_ff, hour_in;
   logic [6:0] minute_ff, minute_in;
   logic [6:0] second_ff, second_in;
   logic [6:0] zhour_ff, zhour_in;
   logic [6:0] zminute_ff, zminute_in;

   logic [7:0] c;
   logic [3:0] dig;
   logic       is_dig;
   logic       is_zulu;
   logic       is_sign;
   logic       leap;
   logic       year_ok;
   logic [4:0] mlen;

   // character classes
   assign c       = item.char_code;
   assign dig     = c[3:0];
   assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_zulu = (c == CH_Z_UP) || (c == CH_Z_LO);
   assign is_sign = (c == CH_PLUS) || (c == CH_DASH);

   // next state for the current character
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      fail_in    = fail_ff;
      year_hi_in = year_hi_ff;
      year_lo_in = year_lo_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      zhour_in   = zhour_ff;
      zminute_in = zminute_ff;
      if (!fail_ff) begin
         unique case (phase_ff)
            PH_FIXED: begin
               priority if (pos_ff == POS_DASH_1 || pos_ff == POS_DASH_2) begin
                  if (c != CH_DASH) fail_in = 1'b1;
               end else if (pos_ff == POS_T) begin
                  if (c != CH_T_UP && c != CH_T_LO) fail_in = 1'b1;
               end else if (pos_ff == POS_COLON_1 || pos_ff == POS_COLON_2) begin
                  if (c != CH_COLON) fail_in = 1'b1;
               end else if (!is_dig) begin
                  fail_in = 1'b1;
               end else if (pos_ff < POS_YEAR_LO) begin
                  year_hi_in = push_digit(year_hi_ff, dig);
               end else if (pos_ff < POS_DASH_1) begin
                  year_lo_in = push_digit(year_lo_ff, dig);
               end else if (pos_ff < POS_DASH_2) begin
                  month_in = push_digit(month_ff, dig);
               end else if (pos_ff < POS_T) begin
                  day_in = push_digit(day_ff, dig);
               end else if (pos_ff < POS_COLON_1) begin
                  hour_in = push_digit(hour_ff, dig);
               end else if (pos_ff < POS_COLON_2) begin
                  minute_in = push_digit(minute_ff, dig);
               end else begin
                  second_in = push_digit(second_ff, dig);
               end
               if (pos_ff >= POS_LAST_FIX) begin
                  pos_in   = '0;
                  phase_in = PH_AFTER_SEC;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            PH_AFTER_SEC: begin
               priority if (c == CH_DOT) begin
                  phase_in = PH_FRAC_NEED;
               end else if (is_zulu) begin
                  phase_in = PH_DONE;
               end else if (is_sign) begin
                  phase_in = PH_ZONE;
                  pos_in   = '0;
               end else begin
                  fail_in = 1'b1;
               end
            end
            PH_FRAC_NEED: begin
               if (is_dig) phase_in = PH_FRAC;
               else        fail_in  = 1'b1;
            end
            PH_FRAC: begin
               priority if (is_dig) begin
                  phase_in = PH_FRAC;
               end else if (is_zulu) begin
                  phase_in = PH_DONE;
               end else if (is_sign) begin
                  phase_in = PH_ZONE;
                  pos_in   = '0;
               end else begin
                  fail_in = 1'b1;
               end
            end
            PH_ZONE: begin
               priority if (pos_ff == ZPOS_COLON) begin
                  if (c != CH_COLON) fail_in = 1'b1;
               end else if (!is_dig) begin
                  fail_in = 1'b1;
               end else if (pos_ff < ZPOS_COLON) begin
                  zhour_in = push_digit(zhour_ff, dig);
               end else begin
                  zminute_in = push_digit(zminute_ff, dig);
               end
               if (pos_ff >= ZPOS_LAST) begin
                  phase_in = PH_DONE;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            // anything after a complete zone breaks the string
            default: fail_in = 1'b1;
         endcase
      end
   end

   // leap year and month length from the updated fields
   assign leap    = (year_lo_in[1:0] == 2'b00) &&
                    ((year_lo_in != 7'd0) || (year_hi_in[1:0] == 2'b00));
   assign year_ok = (year_hi_in != 7'd0) || (year_lo_in != 7'd0);
   assign mlen    = month_length(month_in, leap);

   // verdict for a string that ends with this character
   assign verdict = !fail_in && (phase_in == PH_DONE) && year_ok &&
                    (day_in != 7'd0) && (day_in <= {2'b00, mlen}) &&
                    (hour_in <= MAX_HOUR) && (minute_in <= MAX_MINUTE) &&
                    (second_in <= MAX_SECOND) && (zhour_in <= MAX_HOUR) &&
                    (zminute_in <= MAX_MINUTE);

   // state update, cleared at reset and after each final character
   always_ff @(posedge clock) begin
      if (reset || (go && item.last_char)) begin
         phase_ff   <= PH_FIXED;
         pos_ff     <= '0;
         fail_ff    <= 1'b0;
         year_hi_ff <= '0;
         year_lo_ff <= '0;
         month_ff   <= '0;
         day_ff     <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
         zhour_ff   <= '0;
         zminute_ff <= '0;
      end else if (go) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         fail_ff    <= fail_in;
         year_hi_ff <= year_hi_in;
         year_lo_ff <= year_lo_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
         zhour_ff   <= zhour_in;
         zminute_ff <= zminute_in;
      end
   end

endmodule
